FILE: rtl/core/usv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usv_pkg: shared definitions of the unique value stack
// Command and status codes, field widths and the cell shift control word.
// ----------------------------------------------------------------------------
package usv_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CMD_W   = 2;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage
`default_nettype wire

FILE: rtl/core/unique_value_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unique_value_stack: last-in first-out store that rejects duplicate values
//
// Request channel (req_valid / req_ready) carries one command word: push,
// pop or find, with a 32-bit signed value. Response channel (rsp_valid /
// rsp_ready) returns exactly one word per command: status, popped data,
// position from the bottom and the entry count after the command.
// Storage is a row of shift cells, top of stack in cell 0. Every cell
// compares its entry with the key in parallel; a registered picker then
// selects the bottom-most match.
// Each command passes the compare, pick and update steps in turn; the
// response is registered when the update step completes, and the next
// command is taken only once the update step is done.
// req_ready is high only while no command is in flight; a new command may
// be taken while the previous response still waits. If the receiver stalls,
// the finished command waits in the update step until the response
// register is free.
// Reset empties the stack; no clearing pass is needed.
// ----------------------------------------------------------------------------
module unique_value_stack #(
   parameter int DEPTH = usv_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [usv_pkg::CMD_W-1:0]     req_command,
   input  wire logic signed [usv_pkg::DATA_W-1:0]    req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic             [usv_pkg::STAT_W-1:0]    rsp_status,
   output logic signed      [usv_pkg::DATA_W-1:0]    rsp_data,
   output logic             [usv_pkg::POS_W-1:0]     rsp_position,
   output logic             [usv_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = CNT_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;
   localparam logic [1:0] S_EXEC = 2'd3;

   logic [1:0]                    state_ff;
   logic [1:0]                    state_in;
   logic [CNT_W-1:0]              fill_ff;
   logic [CNT_W-1:0]              fill_in;
   logic [usv_pkg::CMD_W-1:0]     cmd_ff;
   logic [usv_pkg::CMD_W-1:0]     cmd_in;
   logic [usv_pkg::DATA_W-1:0]    key_ff;
   logic [usv_pkg::DATA_W-1:0]    key_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [usv_pkg::STAT_W-1:0]    status_ff;
   logic [usv_pkg::STAT_W-1:0]    status_in;
   logic [usv_pkg::DATA_W-1:0]    data_ff;
   logic [usv_pkg::DATA_W-1:0]    data_in;
   logic [usv_pkg::POS_W-1:0]     pos_ff;
   logic [usv_pkg::POS_W-1:0]     pos_in;
   logic [usv_pkg::COUNT_W-1:0]   count_ff;
   logic [usv_pkg::COUNT_W-1:0]   count_in;

   usv_pkg::shift_type            shift_ctrl;
   logic [usv_pkg::DATA_W-1:0]    entry [DEPTH];
   logic [DEPTH-1:0]              hit;
   logic [DEPTH-1:0]              hit_rev;
   logic [DEPTH-1:0]              live;
   logic                          hit_any;
   logic [IDX_W-1:0]              hit_index;
   logic [EXT_W-1:0]              pos_full;
   logic [IDX_W-1:0]              pos_idx;
   logic                          accept;
   logic                          fire;
   logic                          full;

   // cell row, top of stack in cell 0
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [usv_pkg::DATA_W-1:0] push_src;
      logic [usv_pkg::DATA_W-1:0] pop_src;

      if (k == 0) begin : g_top
         assign push_src = key_ff;
      end else begin : g_mid
         assign push_src = entry[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign pop_src = entry[k];
      end else begin : g_inner
         assign pop_src = entry[k+1];
      end

      assign live[k]              = fill_ff > CNT_W'(k);
      assign hit_rev[DEPTH-1-k]   = hit[k];

      usv_cell u_cell (
         .clock     (clock),
         .ctrl      (shift_ctrl),
         .push_data (push_src),
         .pop_data  (pop_src),
         .key       (key_ff),
         .live      (live[k]),
         .entry     (entry[k]),
         .hit       (hit[k])
      );
   end

   // bottom-most match is the lowest bit of the reversed vector
   usv_prio #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_prio (
      .clock (clock),
      .hits  (hit_rev),
      .any   (hit_any),
      .index (hit_index)
   );

   // position from bottom = fill + index - depth
   assign pos_full = (EXT_W'(fill_ff) + EXT_W'(hit_index)) - EXT_W'(DEPTH);
   assign pos_idx  = pos_full[IDX_W-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full      = (fill_ff == CNT_W'(DEPTH));

   assign cmd_in = accept ? req_command : cmd_ff;
   assign key_in = accept ? $unsigned(req_value) : key_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      shift_ctrl   = '0;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (fire) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = usv_pkg::ST_OK;
               data_in      = '0;
               pos_in       = '0;
               unique case (cmd_ff)
                  usv_pkg::CMD_PUSH: begin
                     priority if (hit_any) begin
                        status_in = usv_pkg::ST_DUP;
                        pos_in    = usv_pkg::POS_W'(pos_idx);
                     end else if (full) begin
                        status_in = usv_pkg::ST_FULL;
                     end else begin
                        shift_ctrl.push = 1'b1;
                        fill_in         = fill_ff + CNT_W'(1);
                     end
                  end
                  usv_pkg::CMD_POP: begin
                     if (fill_ff == '0) begin
                        status_in = usv_pkg::ST_MISS;
                     end else begin
                        shift_ctrl.pop = 1'b1;
                        data_in        = entry[0];
                        fill_in        = fill_ff - CNT_W'(1);
                     end
                  end
                  usv_pkg::CMD_FIND: begin
                     if (hit_any) begin
                        pos_in = usv_pkg::POS_W'(pos_idx);
                     end else begin
                        status_in = usv_pkg::ST_MISS;
                     end
                  end
                  default: begin
                     status_in = usv_pkg::ST_OK;
                  end
               endcase
               count_in = usv_pkg::COUNT_W'(fill_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      pos_ff    <= pos_in;
      count_ff  <= count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_data     = $signed(data_ff);
   assign rsp_position = pos_ff;
   assign rsp_count    = count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill level above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd_ff == usv_pkg::CMD_PUSH && !hit_any && !full)
      |=> fill_ff == $past(fill_ff) + CNT_W'(1))
      else $error("accepted push did not grow the stack");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid && rsp_count == usv_pkg::COUNT_W'(fill_ff))
      else $error("response count differs from fill level");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !fire) |=> state_ff == S_EXEC && $stable(fill_ff))
      else $error("stalled command changed the stack");

endmodule
`default_nettype wire

FILE: rtl/core/usv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usv_cell: one stack cell
// Holds one entry, shifts toward the bottom on push and toward the top on
// pop, and registers its own match against the search key.
// ----------------------------------------------------------------------------
module usv_cell (
   input  wire logic                          clock,
   input  wire usv_pkg::shift_type            ctrl,
   input  wire logic [usv_pkg::DATA_W-1:0]    push_data,
   input  wire logic [usv_pkg::DATA_W-1:0]    pop_data,
   input  wire logic [usv_pkg::DATA_W-1:0]    key,
   input  wire logic                          live,
   output logic      [usv_pkg::DATA_W-1:0]    entry,
   output logic                               hit
);

   logic [usv_pkg::DATA_W-1:0] entry_ff;
   logic [usv_pkg::DATA_W-1:0] entry_in;
   logic                       hit_ff;
   logic                       hit_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.push) begin
         entry_in = push_data;
      end else if (ctrl.pop) begin
         entry_in = pop_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   assign hit_in = live && (entry_ff == key);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule
`default_nettype wire

FILE: rtl/core/usv_prio.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usv_prio: match picker
// Registers the lowest set bit of the match vector, then encodes it.
// ----------------------------------------------------------------------------
module usv_prio #(
   parameter int DEPTH = usv_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = 6
) (
   input  wire logic             clock,
   input  wire logic [DEPTH-1:0] hits,
   output logic                  any,
   output logic      [IDX_W-1:0] index
);

   logic [DEPTH-1:0] onehot_ff;
   logic [DEPTH-1:0] onehot_in;
   logic             any_ff;
   logic             any_in;

   assign onehot_in = hits & (~hits + DEPTH'(1));
   assign any_in    = |hits;

   always_ff @(posedge clock) begin
      onehot_ff <= onehot_in;
      any_ff    <= any_in;
   end

   always_comb begin
      index = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (onehot_ff[k]) begin
            index = index | IDX_W'(k);
         end
      end
   end

   assign any = any_ff;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the unique value stack
// Drives push, pop, find and unused command words through the valid/ready
// request channel with bursty pacing, and stalls the response channel on
// a changing pattern, once for a long hold-off. A tracker class mirrors
// the stack contents and checks every response word in order.
// ----------------------------------------------------------------------------
module tb;
   import usv_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int ITEMS_TOTAL = 1150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_CYCLES = 250;
   localparam int DRAIN_WAIT  = 12;
   localparam int REPORT_MAX  = 10;

   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

   localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] EXTREMES [5] = '{MOST_NEG, MOST_POS, 0, -1, 1};

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] data;
      logic [POS_W-1:0]         position;
      logic [COUNT_W-1:0]       count;
   } stack_answer;

   typedef enum {ALWAYS_READY, MOSTLY_READY, MOSTLY_STALLED, PERIODIC} stall_style;
   typedef enum {FRESH, EXTREME, STORED, POOL} value_kind;
   typedef enum {FILL_UP, DRAIN, MIXED, CHURN} episode_kind;

   class stack_tracker;
      logic signed [DATA_W-1:0] cells [DEPTH];
      int level = 0;
      int failures = 0;
      int received = 0;
      stack_answer answers_due [$];

      function int locate(logic signed [DATA_W-1:0] value);
         for (int i = 0; i < level; i++)
            if (cells[i] == value) return i;
         return -1;
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
         stack_answer due;
         int hit;
         due.status = ST_OK;
         due.data = '0;
         due.position = '0;
         hit = locate(value);
         case (cmd)
            CMD_PUSH: begin
               if (hit >= 0) begin
                  due.status = ST_DUP;
                  due.position = POS_W'(hit);
               end else if (level == DEPTH) begin
                  due.status = ST_FULL;
               end else begin
                  cells[level] = value;
                  level++;
               end
            end
            CMD_POP: begin
               if (level == 0) begin
                  due.status = ST_MISS;
               end else begin
                  level--;
                  due.data = cells[level];
               end
            end
            CMD_FIND: begin
               if (hit >= 0) due.position = POS_W'(hit);
               else due.status = ST_MISS;
            end
            default: ;
         endcase
         due.count = COUNT_W'(level);
         answers_due.push_back(due);
      endfunction

      function void report(string what, stack_answer due, stack_answer got);
         failures++;
         if (failures <= REPORT_MAX)
            $display("%0s: expected st=%0d data=%0d pos=%0d cnt=%0d, got st=%0d data=%0d pos=%0d cnt=%0d",
                     what, due.status, due.data, due.position, due.count,
                     got.status, got.data, got.position, got.count);
      endfunction

      function void check_answer(stack_answer got);
         stack_answer due;
         received++;
         if (answers_due.size() == 0) begin
            due = '{ST_OK, 0, 0, 0};
            report("response word with none outstanding", due, got);
            return;
         end
         due = answers_due.pop_front();
         if (got.status !== due.status || got.data !== due.data ||
             got.position !== due.position || got.count !== due.count)
            report("response word mismatch", due, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_command = CMD_PUSH;
   logic signed [DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic [POS_W-1:0] rsp_position;
   logic [COUNT_W-1:0] rsp_count;

   stack_tracker tracker;
   int sent = 0;
   int burst_left = 0;
   int cycles = 0;

   unique_value_stack #(.DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_position(rsp_position),
      .rsp_count(rsp_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      stack_answer seen;
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_command(req_command, req_value);
         if (rsp_valid && rsp_ready) begin
            seen.status = rsp_status;
            seen.data = rsp_data;
            seen.position = rsp_position;
            seen.count = rsp_count;
            tracker.check_answer(seen);
         end
      end
   end

   // response side stall pattern, with one long hold-off
   initial begin : receiver
      stall_style style;
      int phase_left;
      int period;
      int tick;
      bit held;
      style = ALWAYS_READY;
      phase_left = 0;
      period = 2;
      tick = 0;
      held = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && tracker.received >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (phase_left == 0) begin
            style = stall_style'($urandom_range(0, 3));
            phase_left = $urandom_range(16, 96);
            period = $urandom_range(2, 5);
         end
         phase_left--;
         tick++;
         case (style)
            ALWAYS_READY:   rsp_ready <= 1'b1;
            MOSTLY_READY:   rsp_ready <= ($urandom_range(0, 3) != 0);
            MOSTLY_STALLED: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:        rsp_ready <= (tick % period == 0);
         endcase
      end
   end

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
   endtask

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (cmd != CMD_NOP) sent++;
      pace();
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(value_kind kind);
      case (kind)
         EXTREME: return EXTREMES[$urandom_range(0, 4)];
         STORED: begin
            if (tracker.level == 0) return $urandom;
            return tracker.cells[$urandom_range(0, tracker.level - 1)];
         end
         POOL: return int'($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic value_kind any_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return FRESH;
      if (r < 45) return EXTREME;
      if (r < 80) return STORED;
      return POOL;
   endfunction

   task automatic run_episode(input episode_kind kind);
      int n;
      int r;
      case (kind)
         FILL_UP: begin
            n = DEPTH - tracker.level + $urandom_range(1, 6);
            repeat (n) begin
               r = $urandom_range(0, 99);
               if (r < 15) send_word(CMD_PUSH, pick_value(STORED));
               else if (r < 20) send_word(CMD_FIND, pick_value(STORED));
               else if (r < 25) send_word(CMD_PUSH, pick_value(EXTREME));
               else send_word(CMD_PUSH, pick_value(FRESH));
            end
         end
         DRAIN: begin
            n = tracker.level + $urandom_range(1, 4);
            repeat (n) begin
               if ($urandom_range(0, 7) == 0) send_word(CMD_FIND, pick_value(STORED));
               else send_word(CMD_POP, $urandom);
            end
         end
         MIXED: begin
            n = $urandom_range(20, 60);
            repeat (n) begin
               r = $urandom_range(0, 99);
               if (r < 40) send_word(CMD_PUSH, pick_value(any_kind()));
               else if (r < 65) send_word(CMD_POP, $urandom);
               else if (r < 95) send_word(CMD_FIND, pick_value(any_kind()));
               else send_word(CMD_NOP, $urandom);
            end
         end
         default: begin
            n = $urandom_range(20, 40);
            repeat (n) begin
               r = $urandom_range(0, 99);
               if (r < 45) send_word(CMD_PUSH, pick_value(POOL));
               else if (r < 70) send_word(CMD_FIND, pick_value(POOL));
               else send_word(CMD_POP, $urandom);
            end
         end
      endcase
   endtask

   initial begin : stimulus
      int r;
      tracker = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty store, unused command
      send_word(CMD_FIND, 0);
      send_word(CMD_POP, -1);
      send_word(CMD_NOP, -1);
      // extremes, then duplicates of bottom and top
      send_word(CMD_PUSH, MOST_NEG);
      send_word(CMD_PUSH, MOST_POS);
      send_word(CMD_PUSH, 0);
      send_word(CMD_PUSH, -1);
      send_word(CMD_PUSH, MOST_NEG);
      send_word(CMD_PUSH, -1);
      send_word(CMD_FIND, MOST_POS);
      send_word(CMD_FIND, 32'sh1234_5678);
      send_word(CMD_NOP, 32'sh5555_5555);
      send_word(CMD_POP, 0);
      send_word(CMD_POP, 0);
      send_word(CMD_FIND, 0);
      send_word(CMD_PUSH, 0);
      send_word(CMD_POP, MOST_POS);
      send_word(CMD_POP, 0);
      send_word(CMD_POP, 0);
      send_word(CMD_POP, 0);
      send_word(CMD_PUSH, 1);
      send_word(CMD_FIND, 1);
      send_word(CMD_POP, MOST_NEG);

      while (sent < ITEMS_TOTAL) begin
         r = $urandom_range(0, 99);
         if (r < 25) run_episode(FILL_UP);
         else if (r < 50) run_episode(DRAIN);
         else if (r < 80) run_episode(MIXED);
         else run_episode(CHURN);
      end

      req_valid <= 1'b0;
      while (tracker.answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
